// ===== sv/bmnd_pkg.sv =====
// Shared types and constants for the boolean matrix nilpotency degree block.
package bmnd_pkg;

  // Fixed field widths and the default node count
  localparam int unsigned ROW_W         = 32;
  localparam int unsigned CFG_W         = 6;
  localparam int unsigned DEG_W         = 6;
  localparam int unsigned OUT_TDATA_W   = 8;
  localparam int unsigned MAX_NODES_DEF = 32;

  // Controller states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PEEL
  } bmnd_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_row;   // store the incoming row beat
    logic peel_init;  // seed the remaining-node mask
    logic peel_step;  // remove one round of sink nodes
    logic out_load;   // capture the result into the output register
  } bmnd_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_row;   // row counter sits on the last row in use
    logic peel_done;  // graph empty, or no node removable (cycle)
    logic out_free;   // output register can take a new result
  } bmnd_status_t;

endpackage

// ===== sv/bmnd_ctrl.sv =====
// Controller state machine: row loading and peeling sequence.
module bmnd_ctrl
  import bmnd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  bmnd_status_t st,
  output bmnd_cmd_t    cmd
);

  bmnd_state_t state;
  bmnd_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load_row = 1'b1;
          if (st.last_row) begin
            cmd.peel_init = 1'b1;
            state_next    = ST_PEEL;
          end
        end
      end
      ST_PEEL: begin
        if (!st.peel_done) begin
          cmd.peel_step = 1'b1;
        end else if (st.out_free) begin
          // hold here while an earlier result still waits
          cmd.out_load = 1'b1;
          state_next   = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

// ===== sv/bmnd_dpath.sv =====
// Datapath: row store, size register, peeling unit and output register.
module bmnd_dpath
  import bmnd_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic [ROW_W-1:0]       row_bits,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_data,
  input  bmnd_cmd_t              cmd,
  output bmnd_status_t           st,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int unsigned RW = (MAX_NODES < ROW_W) ? MAX_NODES : ROW_W;
  localparam int unsigned IW = $clog2(MAX_NODES);

  logic [CFG_W-1:0]     size_eff;
  logic [CFG_W-1:0]     row_cnt;
  logic [RW-1:0]        rows [MAX_NODES];
  logic [MAX_NODES-1:0] remaining;
  logic [MAX_NODES-1:0] removable;
  logic [MAX_NODES-1:0] col_mask;
  logic [DEG_W-1:0]     round_cnt;
  logic                 out_nil;
  logic [DEG_W-1:0]     out_deg;
  logic [CFG_W-1:0]     size_clamped;

  // Clamp the written size into 1..MAX_NODES
  always_comb begin
    if (cfg_data == '0) begin
      size_clamped = CFG_W'(1);
    end else if ((CFG_W + 1)'(cfg_data) > (CFG_W + 1)'(MAX_NODES)) begin
      size_clamped = CFG_W'(MAX_NODES);
    end else begin
      size_clamped = cfg_data;
    end
  end

  // Size register and row counter
  always_ff @(posedge clk) begin
    if (rst) begin
      size_eff <= CFG_W'(1);
      row_cnt  <= '0;
    end else if (cfg_we) begin
      size_eff <= size_clamped;
      row_cnt  <= '0;
    end else if (cmd.load_row) begin
      row_cnt <= st.last_row ? '0 : row_cnt + CFG_W'(1);
    end
  end

  // Row store; columns past the size never survive the remaining mask
  always_ff @(posedge clk) begin
    if (cmd.load_row) begin
      rows[row_cnt[IW-1:0]] <= row_bits[RW-1:0];
    end
  end

  // Nodes in use, and nodes with no edge into a remaining node
  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      col_mask[i]  = (CFG_W + 1)'(i) < {1'b0, size_eff};
      removable[i] = remaining[i] && ((rows[i] & remaining[RW-1:0]) == '0);
    end
  end

  // Peeling state
  always_ff @(posedge clk) begin
    if (rst) begin
      remaining <= '0;
      round_cnt <= '0;
    end else if (cmd.peel_init) begin
      remaining <= col_mask;
      round_cnt <= '0;
    end else if (cmd.peel_step) begin
      remaining <= remaining & ~removable;
      round_cnt <= round_cnt + DEG_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_nil <= (remaining == '0);
      out_deg <= (remaining == '0) ? round_cnt : '0;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - DEG_W - 1)'(0), out_deg, out_nil};

  // Status back to the controller
  assign st.last_row  = (row_cnt == size_eff - CFG_W'(1));
  assign st.peel_done = (remaining == '0) || (removable == '0);
  assign st.out_free  = !m_tvalid || m_tready;

  // Checks
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("result loaded over a pending beat");

  a_seed_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.peel_init |=> (remaining != '0))
    else $error("peeling started with no nodes");

  a_step_progress: assert property (@(posedge clk) disable iff (rst)
    cmd.peel_step |-> (removable != '0) && (remaining != '0))
    else $error("peel step with nothing to remove");

  a_deg_bound: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_load && remaining == '0) |-> (round_cnt <= size_eff))
    else $error("degree exceeds matrix size");

endmodule

// ===== sv/bool_matrix_nilpotency_degree.sv =====
// Top level: nilpotency degree of a boolean adjacency matrix, streamed row by row.
// Rows are taken one per cycle while loading, none while peeling; after the last
// row the peeling unit removes one round of nodes per cycle, r rounds in all (at
// most the matrix size, or fewer on a cycle), then loads the result beat into the
// output register. The next load overlaps a waiting result.
// Reset: matrix_size 1, row count 0, no result pending; the row store is not cleared.
module bool_matrix_nilpotency_degree
  import bmnd_pkg::*;
#(
  parameter int unsigned MAX_NODES = MAX_NODES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // config write channel: matrix_size
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_W-1:0]       cfg_data,
  // row beats
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [ROW_W-1:0]       s_tdata,   // [31:0] row_bits
  // result beats
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata    // [0] is_nilpotent, [6:1] degree, [7] zero
);

  bmnd_cmd_t    cmd;
  bmnd_status_t st;

  // Config writes are always taken
  assign cfg_ready = 1'b1;

  bmnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  bmnd_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .row_bits (s_tdata),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .st       (st),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the boolean matrix nilpotency degree block.
module tb;
  import bmnd_pkg::*;

  localparam int MAXN        = MAX_NODES_DEF;
  localparam int SETTLE      = 2 * MAXN + 8;   // longest load-free peel plus margin
  localparam int STALL_LIMIT = 5000;           // cycles with no beat at all
  localparam int RANDOM_ROWS = 2000;
  localparam int IDLE_PCT    = 23;

  typedef struct packed {
    logic             nilpotent;
    logic [DEG_W-1:0] degree;
  } nil_result_t;

  typedef enum int {
    G_DAG,
    G_CHAIN,
    G_CYCLIC,
    G_SELF_LOOP,
    G_NOISE
  } graph_kind_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_W-1:0]       cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [ROW_W-1:0]       s_tdata;   // [31:0] row_bits
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;   // [0] is_nilpotent, [6:1] degree, [7] zero

  bool_matrix_nilpotency_degree #(
    .MAX_NODES(MAXN)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // Predictor state
  logic [CFG_W-1:0] size_reg;
  logic [ROW_W-1:0] stored_rows[MAXN];
  int               row_idx;
  nil_result_t      expected_results[$];

  // Bookkeeping
  bit no_idle;
  int errors;
  int rows_sent;
  int matrices_sent;
  int results_checked;
  int cyclic_seen;
  int cfg_writes;
  int stall_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Effective size: 0 acts as 1, anything above the node count is clamped
  function automatic int used_size();
    int s;
    s = int'(size_reg);
    if (s < 1) s = 1;
    if (s > MAXN) s = MAXN;
    return s;
  endfunction

  function automatic logic [ROW_W-1:0] col_mask(input int s);
    logic [63:0] m;
    m = (64'd1 << s) - 64'd1;
    return m[ROW_W-1:0];
  endfunction

  // Peel sink nodes round by round; a round that removes nothing means a cycle
  function automatic nil_result_t peel_graph(input int s);
    logic [ROW_W-1:0] remaining;
    logic [ROW_W-1:0] removable;
    int               rounds;
    nil_result_t      r;
    remaining   = col_mask(s);
    rounds      = 0;
    r.nilpotent = 1'b1;
    r.degree    = '0;
    while (remaining != '0) begin
      removable = '0;
      for (int i = 0; i < s; i++)
        if (remaining[i] && ((stored_rows[i] & remaining) == '0)) removable[i] = 1'b1;
      if (removable == '0) begin
        r.nilpotent = 1'b0;
        return r;
      end
      remaining &= ~removable;
      rounds++;
    end
    r.degree = rounds[DEG_W-1:0];
    return r;
  endfunction

  function automatic void predict_row(input logic [ROW_W-1:0] row);
    int          s;
    nil_result_t r;
    s = used_size();
    if (row_idx >= s) row_idx = 0;
    stored_rows[row_idx] = row & col_mask(s);
    row_idx++;
    if (row_idx == s) begin
      row_idx = 0;
      r = peel_graph(s);
      if (!r.nilpotent) cyclic_seen++;
      expected_results.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // One row beat; valid stays high into the next call unless a gap is drawn
  task automatic send_row(input logic [ROW_W-1:0] row);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= row;
    do @(posedge clk); while (!s_tready);
    predict_row(row);
    rows_sent++;
    @(negedge clk);
  endtask

  // Sender holds off until every pending result has been taken
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // Size write, only once the block has gone quiet
  task automatic write_size(input logic [CFG_W-1:0] value);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    size_reg = value;
    row_idx  = 0;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Build one graph of the given shape in a shuffled node order and stream it
  task automatic send_matrix(input int s, input graph_kind_t kind);
    logic [ROW_W-1:0] m[MAXN];
    int               order[MAXN];
    int               p, a, b, t;
    for (int i = 0; i < MAXN; i++) begin
      order[i] = i;
      m[i]     = '0;
    end
    for (int i = s - 1; i > 0; i--) begin
      t        = $urandom_range(i);
      a        = order[i];
      order[i] = order[t];
      order[t] = a;
    end
    p = $urandom_range(100);
    if (kind == G_NOISE) begin
      for (int i = 0; i < s; i++) m[i] = $urandom();
    end else begin
      // forward edges in the shuffled order keep the graph acyclic
      for (int i = 0; i < s; i++)
        for (int j = i + 1; j < s; j++)
          if ($urandom_range(99) < p) m[order[i]][order[j]] = 1'b1;
    end
    case (kind)
      G_CHAIN: begin
        for (int i = 0; i + 1 < s; i++) m[order[i]][order[i+1]] = 1'b1;
      end
      G_CYCLIC: begin
        if (s < 2) begin
          m[0][0] = 1'b1;
        end else begin
          // forward path a..b closed by one back edge
          a = $urandom_range(s - 2);
          b = $urandom_range(s - 1, a + 1);
          for (int i = a; i < b; i++) m[order[i]][order[i+1]] = 1'b1;
          m[order[b]][order[a]] = 1'b1;
        end
      end
      G_SELF_LOOP: begin
        a = $urandom_range(s - 1);
        m[a][a] = 1'b1;
      end
      default: ;
    endcase
    // columns past the size must be ignored
    if ($urandom_range(1) == 1)
      for (int i = 0; i < s; i++) m[i] |= $urandom() & ~col_mask(s);
    for (int i = 0; i < s; i++) send_row(m[i]);
    matrices_sent++;
  endtask

  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 70) return CFG_W'($urandom_range(6, 1));
    if (r < 88) return CFG_W'($urandom_range(12, 7));
    if (r < 94) return CFG_W'($urandom_range(31, 13));
    case ($urandom_range(3))
      0:       return CFG_W'(0);
      1:       return CFG_W'(32);
      2:       return CFG_W'(33);
      default: return CFG_W'(63);
    endcase
  endfunction

  function automatic graph_kind_t pick_kind();
    int r;
    r = $urandom_range(99);
    if (r < 50) return G_DAG;
    if (r < 65) return G_CHAIN;
    if (r < 80) return G_CYCLIC;
    if (r < 88) return G_SELF_LOOP;
    return G_NOISE;
  endfunction

  // ---------------- tests ----------------

  // One node: empty row, self-loop, and bits outside the one column
  task automatic test_single_node();
    write_size(CFG_W'(1));
    send_row(32'h0000_0000);
    send_row(32'hFFFF_FFFF);
    send_row(32'hFFFF_FFFE);
    send_row(32'h0000_0001);
  endtask

  // Size 0 behaves as size 1
  task automatic test_size_zero();
    write_size(CFG_W'(0));
    send_row(32'h0000_0000);
    send_row(32'h0000_0001);
  endtask

  // Two nodes: path, cycle through both nodes, no edges, self-loop
  task automatic test_two_nodes();
    write_size(CFG_W'(2));
    send_row(32'h0000_0002);
    send_row(32'h0000_0000);
    send_row(32'h0000_0002);
    send_row(32'h0000_0001);
    send_row(32'hFFFF_FFFC);
    send_row(32'h0000_0000);
    send_row(32'h0000_0001);
    send_row(32'h0000_0000);
  endtask

  // A size write in the middle of a load drops the rows taken so far
  task automatic test_partial_load();
    write_size(CFG_W'(3));
    send_row(32'h0000_0006);
    write_size(CFG_W'(2));
    send_row(32'h0000_0002);
    send_row(32'h0000_0000);
  endtask

  // Oversized setting clamps to the full node count; longest chain
  task automatic test_full_size();
    write_size(CFG_W'(63));
    send_matrix(used_size(), G_CHAIN);
  endtask

  // Sender stops after each matrix until the result is back
  task automatic test_pressure();
    write_size(CFG_W'(4));
    for (int i = 0; i < 3; i++) begin
      send_matrix(used_size(), G_DAG);
      wait_drained();
    end
  endtask

  task automatic test_random_graphs();
    int start_rows;
    int phase;
    int n;
    int s;
    start_rows = rows_sent;
    phase      = 0;
    while (rows_sent - start_rows < RANDOM_ROWS) begin
      no_idle = (phase >= 8 && phase < 16);
      write_size(pick_size());
      s = used_size();
      n = (s > 12) ? $urandom_range(2, 1) : $urandom_range(8, 2);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(99) < 10) wait_drained();
        send_matrix(s, pick_kind());
      end
      // occasionally leave a load unfinished; the next size write drops it
      if (s >= 2 && $urandom_range(99) < 10) begin
        n = $urandom_range(s - 1, 1);
        for (int k = 0; k < n; k++) send_row($urandom());
      end
      phase++;
    end
    no_idle = 1'b0;
  endtask

  task automatic finish_run();
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    $display("Covered %0d size writes, %0d matrices, %0d row beats.",
             cfg_writes, matrices_sent, rows_sent);
    $display("Checked %0d results (%0d cyclic), %0d mismatches.",
             results_checked, cyclic_seen, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  endtask

  // Result sink: random back-pressure
  always @(negedge clk) begin
    m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Result checker
  always @(posedge clk) begin
    nil_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat tdata=0x%02h", m_tdata));
      end else begin
        exp_r = expected_results.pop_front();
        results_checked++;
        if (m_tdata[0] !== exp_r.nilpotent)
          report_mismatch($sformatf("is_nilpotent got %b want %b",
                                    m_tdata[0], exp_r.nilpotent));
        if (m_tdata[6:1] !== exp_r.degree)
          report_mismatch($sformatf("degree got %0d want %0d",
                                    m_tdata[6:1], exp_r.degree));
        if (m_tdata[7] !== 1'b0)
          report_mismatch($sformatf("pad bit got %b", m_tdata[7]));
      end
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles, %0d results pending",
               STALL_LIMIT, expected_results.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    m_tready     = 1'b0;
    no_idle      = 1'b0;
    errors       = 0;
    rows_sent    = 0;
    matrices_sent   = 0;
    results_checked = 0;
    cyclic_seen  = 0;
    cfg_writes   = 0;
    stall_cycles = 0;
    size_reg     = CFG_W'(1);
    row_idx      = 0;
    for (int i = 0; i < MAXN; i++) stored_rows[i] = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_single_node();
    test_size_zero();
    test_two_nodes();
    test_partial_load();
    test_full_size();
    test_pressure();
    test_random_graphs();
    finish_run();
  end

endmodule
